// ----- hdl/blcp_pkg.sv -----
// Package for the binomial lattice call pricer.
// Holds micro-op and state codes, the control/status structs and the Q30 helpers.
// No dependencies.
`timescale 1ns / 1ps

package blcp_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd5;

    localparam logic [31:0] RST_STRIKE   = 32'd0;
    localparam logic [8:0]  RST_STEPS    = 9'd100;
    localparam logic [31:0] RST_UP       = 32'h4000_0000;
    localparam logic [31:0] RST_DOWN     = 32'h4000_0000;
    localparam logic [30:0] RST_PROB     = 31'h2000_0000;
    localparam logic [30:0] RST_DISCOUNT = 31'h4000_0000;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [65:0] HALF_Q30 = 66'h2000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LF_START,
        OP_LF_MUL,
        OP_LF_RND,
        OP_LF_WRITE,
        OP_LF_BASE,
        OP_FD_INIT,
        OP_FD_RD0,
        OP_FD_RD1,
        OP_FD_M1,
        OP_FD_M2,
        OP_FD_M3,
        OP_FD_WR,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LF_START,
        ST_LF_MUL,
        ST_LF_RND,
        ST_LF_WRITE,
        ST_LF_BASE,
        ST_FD_INIT,
        ST_FD_RD0,
        ST_FD_RD1,
        ST_FD_M1,
        ST_FD_M2,
        ST_FD_M3,
        ST_FD_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic k_done;
        logic m_done;
        logic j_last;
        logic t_last;
        logic out_busy;
    } t_sts;

    // (v + 2^29) >> 30, saturated to 32 bits
    function automatic logic [31:0] f_round_q30(input logic [64:0] v);
        logic [65:0] s;
        logic [35:0] hi;
        s  = {1'b0, v} + HALF_Q30;
        hi = s[65:30];
        return (|hi[35:32]) ? 32'hFFFF_FFFF : hi[31:0];
    endfunction

    function automatic logic [30:0] f_clamp_one(input logic [30:0] v);
        return (v > ONE_Q30) ? ONE_Q30 : v;
    endfunction

endpackage

// ----- hdl/binomial_lattice_call_pricer.sv -----
// Each climb of a leaf up the u chain passes through LF_MUL and LF_RND; each fold node
// passes through FD_RD0, FD_RD1, FD_M1, FD_M2, FD_M3 and FD_WR in that order.
// Throughput: one item at a time; the single shared multiplier and the single read port
// of the row memory set the pace. The next item is taken while a result waits.
// Reset (synchronous, active low) restores the register defaults, idles the FSM and
// stalls the input; the row memory is not cleared, every entry is written before read.
`timescale 1ns / 1ps

module binomial_lattice_call_pricer
    import blcp_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 256
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_spot_price,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_option_value
);

    // Configuration registers; the user must write them only while idle, the block does not enforce it.
    logic [31:0] r_strike_level;
    logic [8:0]  r_step_count;
    logic [31:0] r_up_factor;
    logic [31:0] r_down_factor;
    logic [30:0] r_prob_up;
    logic [30:0] r_step_discount;

    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike_level  <= RST_STRIKE;
            r_step_count    <= RST_STEPS;
            r_up_factor     <= RST_UP;
            r_down_factor   <= RST_DOWN;
            r_prob_up       <= RST_PROB;
            r_step_discount <= RST_DISCOUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STRIKE:   r_strike_level  <= i_cfg_data;
                CFG_STEPS:    r_step_count    <= i_cfg_data[8:0];
                CFG_UP:       r_up_factor     <= i_cfg_data;
                CFG_DOWN:     r_down_factor   <= i_cfg_data;
                CFG_PROB:     r_prob_up       <= i_cfg_data[30:0];
                CFG_DISCOUNT: r_step_discount <= i_cfg_data[30:0];
                default:      ; // unmapped index: dropped
            endcase
        end
    end

    // FSM: leaf build (base walks down the d chain, each leaf climbs the u chain),
    // payoff write, then N backward folds in place over the row memory.
    blcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    blcp_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_spot_price    (i_spot_price),
        .i_strike_level  (r_strike_level),
        .i_step_count    (r_step_count),
        .i_up_factor     (r_up_factor),
        .i_down_factor   (r_down_factor),
        .i_prob_up       (r_prob_up),
        .i_step_discount (r_step_discount),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_option_value  (o_option_value)
    );

endmodule

// ----- hdl/blcp_ctrl.sv -----
// Controller FSM for the binomial lattice call pricer.
// Sequences leaf build and backward fold; depends on blcp_pkg.
`timescale 1ns / 1ps

module blcp_ctrl
    import blcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_LF_START;
            ST_LF_START: n_state = ST_LF_MUL;
            ST_LF_MUL:   n_state = i_sts.k_done ? ST_LF_WRITE : ST_LF_RND;
            ST_LF_RND:   n_state = ST_LF_MUL;
            ST_LF_WRITE: n_state = i_sts.m_done ? ST_FD_INIT : ST_LF_BASE;
            ST_LF_BASE:  n_state = ST_LF_START;
            ST_FD_INIT:  n_state = ST_FD_RD0;
            ST_FD_RD0:   n_state = ST_FD_RD1;
            ST_FD_RD1:   n_state = ST_FD_M1;
            ST_FD_M1:    n_state = ST_FD_M2;
            ST_FD_M2:    n_state = ST_FD_M3;
            ST_FD_M3:    n_state = ST_FD_WR;
            ST_FD_WR:    n_state = (i_sts.j_last && i_sts.t_last) ? ST_DONE : ST_FD_RD0;
            ST_DONE:     if (!i_sts.out_busy) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                // held off while in reset
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) o_cmd.op = OP_LOAD;
            end
            ST_LF_START: o_cmd.op = OP_LF_START;
            ST_LF_MUL:   o_cmd.op = OP_LF_MUL;
            ST_LF_RND:   o_cmd.op = OP_LF_RND;
            ST_LF_WRITE: o_cmd.op = OP_LF_WRITE;
            ST_LF_BASE:  o_cmd.op = OP_LF_BASE;
            ST_FD_INIT:  o_cmd.op = OP_FD_INIT;
            ST_FD_RD0:   o_cmd.op = OP_FD_RD0;
            ST_FD_RD1:   o_cmd.op = OP_FD_RD1;
            ST_FD_M1:    o_cmd.op = OP_FD_M1;
            ST_FD_M2:    o_cmd.op = OP_FD_M2;
            ST_FD_M3:    o_cmd.op = OP_FD_M3;
            ST_FD_WR:    o_cmd.op = OP_FD_WR;
            ST_DONE:     if (!i_sts.out_busy) o_cmd.op = OP_OUT;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input not stalled while busy");
    a_load_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |=> (r_state == ST_LF_START))
        else $error("load did not start leaf build");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_sts.out_busy) |=> (r_state == ST_IDLE))
        else $error("result not handed off");

endmodule

// ----- hdl/blcp_dp.sv -----
// Datapath for the binomial lattice call pricer: row memory, shared multiplier,
// counters and output register. Depends on blcp_pkg.
`timescale 1ns / 1ps

module blcp_dp
    import blcp_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_spot_price,
    input  logic [31:0] i_strike_level,
    input  logic [8:0]  i_step_count,
    input  logic [31:0] i_up_factor,
    input  logic [31:0] i_down_factor,
    input  logic [30:0] i_prob_up,
    input  logic [30:0] i_step_discount,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_option_value
);

    localparam int unsigned CW    = $clog2(MAX_STEPS + 1);
    localparam int unsigned DEPTH = MAX_STEPS + 1;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;
    logic [CW-1:0] rd_addr;
    logic          mem_we;
    logic [CW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [CW-1:0] r_n, r_m, r_k, r_j, r_t;
    logic [31:0]   r_base, r_x;
    logic [63:0]   r_prod;
    logic [64:0]   r_acc;
    logic [31:0]   r_out;
    logic          r_ovalid;

    logic [CW-1:0] n_eff;
    logic [30:0]   p_c, q_c, disc_c;
    logic [31:0]   mul_a, mul_b;
    logic [31:0]   rnd_prod, mix, payoff;

    always_comb begin
        if (i_step_count == 9'd0) begin
            n_eff = CW'(1);
        end else if (32'(i_step_count) > MAX_STEPS) begin
            n_eff = CW'(MAX_STEPS);
        end else begin
            n_eff = CW'(i_step_count);
        end
    end

    assign p_c      = f_clamp_one(i_prob_up);
    assign q_c      = ONE_Q30 - p_c;
    assign disc_c   = f_clamp_one(i_step_discount);
    assign rnd_prod = f_round_q30({1'b0, r_prod});
    assign mix      = f_round_q30(r_acc);
    assign payoff   = (r_x > i_strike_level) ? (r_x - i_strike_level) : 32'd0;

    always_comb begin
        mul_a = r_x;
        mul_b = i_up_factor;
        case (i_cmd.op)
            OP_LF_WRITE: begin
                mul_a = r_base;
                mul_b = i_down_factor;
            end
            OP_FD_RD1: begin
                mul_a = {1'b0, q_c};
                mul_b = r_rd;
            end
            OP_FD_M1: begin
                mul_a = {1'b0, p_c};
                mul_b = r_rd;
            end
            OP_FD_M3: begin
                mul_a = mix;
                mul_b = {1'b0, disc_c};
            end
            default: begin
                mul_a = r_x;
                mul_b = i_up_factor;
            end
        endcase
    end

    assign rd_addr = (i_cmd.op == OP_FD_RD1) ? CW'(r_j + 1'b1) : r_j;
    assign mem_we  = (i_cmd.op == OP_LF_WRITE) || (i_cmd.op == OP_FD_WR);
    assign wr_addr = (i_cmd.op == OP_LF_WRITE) ? (r_n - r_m) : r_j;
    assign wr_data = (i_cmd.op == OP_LF_WRITE) ? payoff : rnd_prod;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_base <= i_spot_price;
                r_m    <= '0;
                r_n    <= n_eff;
            end
            OP_LF_START: begin
                r_x <= r_base;
                r_k <= '0;
            end
            OP_LF_MUL:   r_prod <= mul_a * mul_b;
            OP_LF_RND: begin
                r_x <= rnd_prod;
                r_k <= r_k + 1'b1;
            end
            OP_LF_WRITE: r_prod <= mul_a * mul_b;
            OP_LF_BASE: begin
                r_base <= rnd_prod;
                r_m    <= r_m + 1'b1;
            end
            OP_FD_INIT: begin
                r_t <= r_n;
                r_j <= '0;
            end
            OP_FD_RD1:   r_prod <= mul_a * mul_b;
            OP_FD_M1: begin
                r_acc  <= {1'b0, r_prod};
                r_prod <= mul_a * mul_b;
            end
            OP_FD_M2:    r_acc <= r_acc + {1'b0, r_prod};
            OP_FD_M3:    r_prod <= mul_a * mul_b;
            OP_FD_WR: begin
                if (o_sts.j_last) begin
                    r_t <= r_t - 1'b1;
                    r_j <= '0;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            OP_OUT:      r_out <= rnd_prod;
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.k_done   = (r_k == (r_n - r_m));
    assign o_sts.m_done   = (r_m == r_n);
    assign o_sts.j_last   = (r_j == (r_t - 1'b1));
    assign o_sts.t_last   = (r_t == CW'(1));
    assign o_sts.out_busy = r_ovalid && i_out_stall;

    assign o_out_valid    = r_ovalid;
    assign o_option_value = r_out;

    a_fold_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FD_RD0) |-> (r_j < r_t))
        else $error("fold index beyond level");
    a_leaf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LF_MUL) |-> (r_m <= r_n))
        else $error("leaf counter overran step count");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> !(r_ovalid && i_out_stall))
        else $error("result overwrote a pending result");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for binomial_lattice_call_pricer.
// Holds a price predictor and a scoreboard, and drives random config, spot prices and
// stalls. Depends on hdl/blcp_pkg.sv and hdl/binomial_lattice_call_pricer.sv.
`timescale 1ns / 1ps

// Scoreboard: mirrors the config registers, prices each accepted spot, checks results.
class call_value_board;
    bit [31:0]       strike;
    bit [8:0]        steps;
    bit [31:0]       up_mul;
    bit [31:0]       down_mul;
    bit [30:0]       prob;
    bit [30:0]       disc;
    bit [31:0]       lattice_row [0:256];
    bit [31:0]       pending_values [$];
    int              mismatches;

    function new();
        strike     = blcp_pkg::RST_STRIKE;
        steps      = blcp_pkg::RST_STEPS;
        up_mul     = blcp_pkg::RST_UP;
        down_mul   = blcp_pkg::RST_DOWN;
        prob       = blcp_pkg::RST_PROB;
        disc       = blcp_pkg::RST_DISCOUNT;
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            blcp_pkg::CFG_STRIKE:   strike   = data;
            blcp_pkg::CFG_STEPS:    steps    = data[8:0];
            blcp_pkg::CFG_UP:       up_mul   = data;
            blcp_pkg::CFG_DOWN:     down_mul = data;
            blcp_pkg::CFG_PROB:     prob     = data[30:0];
            blcp_pkg::CFG_DISCOUNT: disc     = data[30:0];
            default: ;
        endcase
    endfunction

    // (a*b + 2^29) >> 30, saturated
    function bit [31:0] scale_q30(bit [31:0] a, bit [31:0] b);
        bit [63:0] r;
        r = ({32'd0, a} * {32'd0, b} + 64'h2000_0000) >> 30;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function void note_spot(bit [31:0] spot);
        int unsigned n;
        bit [31:0]   p;
        bit [31:0]   q;
        bit [31:0]   dsc;
        bit [31:0]   px;
        bit [63:0]   sum;
        n   = (steps == 0) ? 1 : ((steps > 256) ? 256 : steps);
        p   = (prob > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, prob};
        q   = 32'h4000_0000 - p;
        dsc = (disc > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, disc};
        // expiry leaves and their call payoffs
        for (int j = 0; j <= n; j++) begin
            px = spot;
            for (int k = 0; k < n - j; k++) px = scale_q30(px, down_mul);
            for (int k = 0; k < j; k++) px = scale_q30(px, up_mul);
            lattice_row[j] = (px > strike) ? px - strike : 32'd0;
        end
        // backward induction
        for (int t = n; t > 0; t--) begin
            for (int j = 0; j < t; j++) begin
                sum = {32'd0, p} * {32'd0, lattice_row[j+1]}
                    + {32'd0, q} * {32'd0, lattice_row[j]} + 64'h2000_0000;
                sum = sum >> 30;
                if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
                lattice_row[j] = scale_q30(sum[31:0], dsc);
            end
        end
        pending_values.push_back(lattice_row[0]);
    endfunction

    function void check_value(bit [31:0] got);
        bit [31:0] want;
        if (pending_values.size() == 0) begin
            $error("option_value: unexpected transfer, actual %h", got);
            mismatches++;
            return;
        end
        want = pending_values.pop_front();
        if (got !== want) begin
            $error("option_value: expected %h, actual %h", want, got);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return pending_values.size();
    endfunction
endclass

module tb;
    import blcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam logic [31:0] ONE = 32'h4000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] spot_price = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] option_value;

    call_value_board board = new();
    bit          hold_off_req = 1'b0;
    int unsigned cycle_count = 0;

    always #1 clk = ~clk;

    binomial_lattice_call_pricer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_spot_price   (spot_price),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_option_value (option_value)
    );

    // Watchdog: any hang is a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binomial_lattice_call_pricer regression: fail");
            $finish;
        end
    end

    // Result monitor: every output transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_value(option_value);
    end

    // Receiver stalls: mostly open stretches, short stalls, a few long ones.
    // A hold-off request stalls for a long stretch so the block backs up.
    initial begin
        int r;
        int len;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    len = $urandom_range(1, 30);
                    out_stall <= 1'b0;
                end else if (r < 95) begin
                    len = $urandom_range(1, 4);
                    out_stall <= 1'b1;
                end else begin
                    len = $urandom_range(20, 120);
                    out_stall <= 1'b1;
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    // Drop valid, then wait until every predicted value has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we once the batch is done.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic load_pricing(logic [31:0] strike, logic [31:0] steps, logic [31:0] up,
                                logic [31:0] down, logic [31:0] prob, logic [31:0] disc);
        drain();
        write_reg(CFG_STRIKE, strike);
        write_reg(CFG_STEPS, steps);
        write_reg(CFG_UP, up);
        write_reg(CFG_DOWN, down);
        write_reg(CFG_PROB, prob);
        write_reg(CFG_DISCOUNT, disc);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one spot price; hold it until the transfer happens.
    // Valid stays up after the transfer; the next offer or drain() sets it.
    task automatic send_spot(logic [31:0] spot, bit no_gap = 1'b0);
        int r;
        r = $urandom_range(0, 99);
        if (!no_gap && r >= 60) begin
            in_valid <= 1'b0;
            repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 80)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        spot_price <= spot;
        do @(posedge clk); while (in_stall);
        board.note_spot(spot);
    endtask

    // Factors near one so prices stay in a sane band; d is roughly 1/u. Wild mode loads raw random registers.
    task automatic load_random_market(int unsigned max_steps, bit wild);
        logic [31:0] u;
        logic [31:0] d;
        u = ONE + $urandom_range(0, 32'h0800_0000);
        d = 32'(64'h1000_0000_0000_0000 / u);
        if (wild)
            load_pricing($urandom, $urandom_range(0, max_steps), $urandom, $urandom,
                         $urandom, $urandom);
        else
            load_pricing($urandom_range(0, 32'h0100_0000), $urandom_range(1, max_steps),
                         u, d, $urandom_range(0, ONE), $urandom_range(ONE / 2, ONE));
    endtask

    initial begin
        bit wild;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: 100 steps, u = d = 1, no strike
        send_spot(32'h0001_8000);

        // directed corners
        load_pricing(32'h0001_0000, 4, 32'h4400_0000, 32'h3C3C_3C3C, ONE / 2, 32'h3FF0_0000);
        send_spot(32'd0);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'h0001_0000);
        send_spot(32'h0000_0001);
        // strike at its top: payoff always zero
        load_pricing(32'hFFFF_FFFF, 3, 32'h4800_0000, 32'h3900_0000, ONE / 3, ONE);
        send_spot(32'hFFFF_FFFF);
        // zero steps acts as one; u at its top saturates the leaf
        load_pricing(32'd0, 0, 32'hFFFF_FFFF, 32'd0, ONE, ONE);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'h1234_5678);
        // probability and discount above one clamp; bit 31 of the data is dropped
        load_pricing(32'h0000_8000, 1, 32'h5000_0000, 32'h3333_3333, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        send_spot(32'h0002_0000);
        load_pricing(32'h0000_8000, 2, 32'h5000_0000, 32'h3333_3333, 32'h0, 32'h0);
        send_spot(32'h0002_0000);
        // writes past the register list are ignored
        drain();
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        write_reg(CFG_LAST, 32'h0000_0003);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_spot(32'h0003_0000);
        // step count above its field is masked, low bits give the largest lattice
        load_pricing(32'h0001_0000, 32'hFFFF_FF00, 32'h4080_0000, 32'h3F80_FE04,
                     ONE / 2, 32'h3FFF_0000);
        send_spot(32'h0001_2000);

        // random phases: mostly well-behaved markets, some with raw random registers
        for (int ph = 0; ph < 11; ph++) begin
            wild = ($urandom_range(0, 3) == 0);
            load_random_market((ph == 5) ? 30 : 10, wild);
            if (ph == 3) begin
                // back-pressure: receiver holds off while spots keep coming
                hold_off_req = 1'b1;
                for (int i = 0; i < 6; i++) send_spot($urandom_range(0, 32'h00FF_FFFF), 1'b1);
            end
            for (int i = 0; i < 9; i++) begin
                if ($urandom_range(0, 4) == 0) send_spot($urandom);
                else send_spot($urandom_range(0, 32'h0200_0000));
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("binomial_lattice_call_pricer regression: pass");
        else
            $display("binomial_lattice_call_pricer regression: fail");
        $finish;
    end
endmodule
